>>> rtl/frb_pkg.sv
`timescale 1ns / 1ps

package frb_pkg;

	localparam int MAX_FRAME   = 4096;
	localparam int STORE_DEPTH = 8192;
	localparam int FRAME_SLOTS = 64;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 13;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int USED_W = $clog2(STORE_DEPTH + 1);
	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int QCNT_W = $clog2(FRAME_SLOTS + 1);
	localparam int CMD_W  = 2;
	localparam int STS_W  = 3;

	localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

	localparam logic [LEN_W-1:0] MAX_FRAME_RESET = LEN_W'(1024);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_FLUSH = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK         = 3'd0,
		STS_TOO_LONG   = 3'd1,
		STS_BAD_CONFIG = 3'd2,
		STS_NO_FRAME   = 3'd3,
		STS_FULL       = 3'd4
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [BYTE_W-1:0]   out_byte;
		logic                byte_valid;
		logic                frame_last;
		logic                frame_empty;
		logic [LEN_W-1:0]    partial_count;
	} res_t;

	typedef struct packed {
		logic                wr_en;
		logic [ADDR_W-1:0]   wr_addr;
		logic [BYTE_W-1:0]   wr_data;
		logic                rd_en;
		logic [ADDR_W-1:0]   rd_addr;
	} store_req_t;

	typedef struct packed {
		logic                wr_en;
		logic [SLOT_W-1:0]   wr_addr;
		logic [LEN_W-1:0]    wr_data;
		logic                rd_en;
		logic [SLOT_W-1:0]   rd_addr;
	} queue_req_t;

endpackage

>>> rtl/newline_frame_receive_buffer.sv
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// in        in_valid / in_ready        command, data_byte
// out       out_valid / out_ready      status, out_byte, byte_valid, frame_last,
//                                      frame_empty, partial_count
// config    cfg_wr_en                  cfg_wr_data (max_frame_bytes)
//
// Push, flush and idle commands answer from the idle state; a pop first issues
// the registered read of the length queue and byte store together, then answers.
// One request is in flight at a time, so store accesses never overlap.
// Reset clears pointers and counts at once; the stores need no clearing pass.
// A full output register stalls the input until out_ready takes the result.

module newline_frame_receive_buffer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [frb_pkg::LEN_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [frb_pkg::CMD_W-1:0]     command,
	input  logic [frb_pkg::BYTE_W-1:0]    data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [frb_pkg::STS_W-1:0]     status,
	output logic [frb_pkg::BYTE_W-1:0]    out_byte,
	output logic                          byte_valid,
	output logic                          frame_last,
	output logic                          frame_empty,
	output logic [frb_pkg::LEN_W-1:0]     partial_count
);

	import frb_pkg::*;

	store_req_t          store_req;
	queue_req_t          queue_req;
	logic [BYTE_W-1:0]   store_rd_data;
	logic [LEN_W-1:0]    queue_rd_data;
	res_t                res;
	res_t                out_q;
	logic                res_valid;
	logic                out_valid_q;
	logic                slot_free;

	assign slot_free = !out_valid_q || out_ready;

	frb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_byte_store (
		.clk     (clk),
		.wr_en   (store_req.wr_en),
		.wr_addr (store_req.wr_addr),
		.wr_data (store_req.wr_data),
		.rd_en   (store_req.rd_en),
		.rd_addr (store_req.rd_addr),
		.rd_data (store_rd_data)
	);

	frb_ram #(
		.WIDTH (LEN_W),
		.DEPTH (FRAME_SLOTS)
	) u_length_queue (
		.clk     (clk),
		.wr_en   (queue_req.wr_en),
		.wr_addr (queue_req.wr_addr),
		.wr_data (queue_req.wr_data),
		.rd_en   (queue_req.rd_en),
		.rd_addr (queue_req.rd_addr),
		.rd_data (queue_rd_data)
	);

	frb_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.data_byte     (data_byte),
		.slot_free     (slot_free),
		.res_valid     (res_valid),
		.res           (res),
		.store_req     (store_req),
		.store_rd_data (store_rd_data),
		.queue_req     (queue_req),
		.queue_rd_data (queue_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign out_byte      = out_q.out_byte;
	assign byte_valid    = out_q.byte_valid;
	assign frame_last    = out_q.frame_last;
	assign frame_empty   = out_q.frame_empty;
	assign partial_count = out_q.partial_count;

endmodule

>>> rtl/frb_ram.sv
`timescale 1ns / 1ps

module frb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// hold read data between reads
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/frb_core.sv
`timescale 1ns / 1ps

module frb_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [frb_pkg::LEN_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [frb_pkg::CMD_W-1:0]     command,
	input  logic [frb_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          slot_free,
	output logic                          res_valid,
	output frb_pkg::res_t                 res,
	output frb_pkg::store_req_t           store_req,
	input  logic [frb_pkg::BYTE_W-1:0]    store_rd_data,
	output frb_pkg::queue_req_t           queue_req,
	input  logic [frb_pkg::LEN_W-1:0]     queue_rd_data
);

	import frb_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	state_t              state_q, state_d;
	logic [LEN_W-1:0]    max_frame_q;
	logic [ADDR_W-1:0]   wr_ptr_q, wr_ptr_d;
	logic [ADDR_W-1:0]   rd_ptr_q, rd_ptr_d;
	logic [USED_W-1:0]   used_q, used_d;
	logic [LEN_W-1:0]    partial_q, partial_d;
	logic [SLOT_W-1:0]   head_q, head_d;
	logic [SLOT_W-1:0]   tail_q, tail_d;
	logic [QCNT_W-1:0]   qcount_q, qcount_d;
	logic [LEN_W-1:0]    pop_off_q, pop_off_d;
	logic [BYTE_W-1:0]   last_byte_q;
	logic [LEN_W-1:0]    limit;
	logic [LEN_W-1:0]    pop_off_inc;
	logic [LEN_W-1:0]    frame_len;
	logic                strip_cr;
	logic                accept;
	logic                push_store;

	assign limit = (max_frame_q > LEN_W'(MAX_FRAME)) ? LEN_W'(MAX_FRAME) : max_frame_q;
	assign in_ready = (state_q == ST_IDLE) && slot_free;
	assign accept = in_valid && in_ready;
	assign pop_off_inc = pop_off_q + LEN_W'(1);
	// last stored byte of the partial frame sits in last_byte_q
	assign strip_cr = (partial_q != '0) && (last_byte_q == CHAR_CR);
	assign frame_len = partial_q - LEN_W'(strip_cr);

	always_comb begin
		state_d    = state_q;
		wr_ptr_d   = wr_ptr_q;
		rd_ptr_d   = rd_ptr_q;
		used_d     = used_q;
		partial_d  = partial_q;
		head_d     = head_q;
		tail_d     = tail_q;
		qcount_d   = qcount_q;
		pop_off_d  = pop_off_q;
		push_store = 1'b0;
		res_valid  = 1'b0;
		res        = '0;
		res.status = STS_OK;
		store_req  = '0;
		queue_req  = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_t'(command))
						CMD_PUSH: begin
							res_valid = 1'b1;
							if (limit == '0) begin
								res.status = STS_BAD_CONFIG;
								state_d    = ST_IDLE;
								wr_ptr_d   = '0;
								rd_ptr_d   = '0;
								used_d     = '0;
								partial_d  = '0;
								head_d     = '0;
								tail_d     = '0;
								qcount_d   = '0;
								pop_off_d  = '0;
							end else if (data_byte == CHAR_LF) begin
								if (qcount_q >= QCNT_W'(FRAME_SLOTS)) begin
									res.status = STS_FULL;
									wr_ptr_d   = '0;
									rd_ptr_d   = '0;
									used_d     = '0;
									partial_d  = '0;
									head_d     = '0;
									tail_d     = '0;
									qcount_d   = '0;
									pop_off_d  = '0;
								end else begin
									// drop a carriage return just before the newline
									wr_ptr_d          = wr_ptr_q - ADDR_W'(strip_cr);
									used_d            = used_q - USED_W'(strip_cr);
									queue_req.wr_en   = 1'b1;
									queue_req.wr_addr = tail_q;
									queue_req.wr_data = frame_len;
									tail_d            = tail_q + SLOT_W'(1);
									qcount_d          = qcount_q + QCNT_W'(1);
									partial_d         = '0;
								end
							end else if (partial_q >= limit) begin
								res.status = STS_TOO_LONG;
								wr_ptr_d   = '0;
								rd_ptr_d   = '0;
								used_d     = '0;
								partial_d  = '0;
								head_d     = '0;
								tail_d     = '0;
								qcount_d   = '0;
								pop_off_d  = '0;
							end else if (used_q >= USED_W'(STORE_DEPTH)) begin
								res.status = STS_FULL;
								wr_ptr_d   = '0;
								rd_ptr_d   = '0;
								used_d     = '0;
								partial_d  = '0;
								head_d     = '0;
								tail_d     = '0;
								qcount_d   = '0;
								pop_off_d  = '0;
							end else begin
								push_store        = 1'b1;
								store_req.wr_en   = 1'b1;
								store_req.wr_addr = wr_ptr_q;
								store_req.wr_data = data_byte;
								wr_ptr_d          = wr_ptr_q + ADDR_W'(1);
								used_d            = used_q + USED_W'(1);
								partial_d         = partial_q + LEN_W'(1);
							end
						end
						CMD_POP: begin
							if (qcount_q == '0) begin
								res_valid  = 1'b1;
								res.status = STS_NO_FRAME;
							end else begin
								// fetch head length and next byte together
								queue_req.rd_en   = 1'b1;
								queue_req.rd_addr = head_q;
								store_req.rd_en   = 1'b1;
								store_req.rd_addr = rd_ptr_q;
								state_d           = ST_POP;
							end
						end
						CMD_FLUSH: begin
							res_valid = 1'b1;
							wr_ptr_d  = '0;
							rd_ptr_d  = '0;
							used_d    = '0;
							partial_d = '0;
							head_d    = '0;
							tail_d    = '0;
							qcount_d  = '0;
							pop_off_d = '0;
						end
						default: begin
							res_valid = 1'b1;
						end
					endcase
				end
			end
			ST_POP: begin
				// wait for the output slot; read data holds meanwhile
				if (slot_free) begin
					res_valid = 1'b1;
					state_d   = ST_IDLE;
					if (queue_rd_data == '0) begin
						res.frame_last  = 1'b1;
						res.frame_empty = 1'b1;
						head_d          = head_q + SLOT_W'(1);
						qcount_d        = qcount_q - QCNT_W'(1);
						pop_off_d       = '0;
					end else begin
						res.out_byte   = store_rd_data;
						res.byte_valid = 1'b1;
						rd_ptr_d       = rd_ptr_q + ADDR_W'(1);
						if (used_q != '0) begin
							used_d = used_q - USED_W'(1);
						end
						pop_off_d = pop_off_inc;
						if (pop_off_inc >= queue_rd_data) begin
							res.frame_last = 1'b1;
							head_d         = head_q + SLOT_W'(1);
							qcount_d       = qcount_q - QCNT_W'(1);
							pop_off_d      = '0;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		res.partial_count = partial_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_frame_q <= MAX_FRAME_RESET;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			used_q      <= '0;
			partial_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			qcount_q    <= '0;
			pop_off_q   <= '0;
		end else begin
			state_q   <= state_d;
			wr_ptr_q  <= wr_ptr_d;
			rd_ptr_q  <= rd_ptr_d;
			used_q    <= used_d;
			partial_q <= partial_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			qcount_q  <= qcount_d;
			pop_off_q <= pop_off_d;
			if (cfg_wr_en) begin
				max_frame_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_store) begin
			last_byte_q <= data_byte;
		end
	end

endmodule

>>> test/frame_buffer_checker.sv
`timescale 1ns / 1ps

module frame_buffer_checker
	import frb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [LEN_W-1:0]     cfg_wr_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [CMD_W-1:0]     command,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [STS_W-1:0]     status,
	input  logic [BYTE_W-1:0]    out_byte,
	input  logic                 byte_valid,
	input  logic                 frame_last,
	input  logic                 frame_empty,
	input  logic [LEN_W-1:0]     partial_count,
	output int                   fail_count,
	output int                   pending_results,
	output int                   results_checked,
	output int                   frames_popped,
	output int                   error_responses
);

	localparam int AWAIT_W     = 4;
	localparam int AWAIT_DEPTH = 1 << AWAIT_W;

	logic [BYTE_W-1:0]  kept_bytes [STORE_DEPTH];
	logic [LEN_W-1:0]   frame_lengths [FRAME_SLOTS];
	int unsigned        wr_ptr, rd_ptr, used_bytes, partial_len;
	int unsigned        head, tail, frames_held, pop_pos;
	logic [LEN_W-1:0]   max_len;
	res_t               awaited [AWAIT_DEPTH];
	logic [AWAIT_W-1:0] await_rd, await_wr;
	int                 await_cnt;
	res_t               want;

	function automatic void clear_state();
		wr_ptr = 0;
		rd_ptr = 0;
		used_bytes = 0;
		partial_len = 0;
		head = 0;
		tail = 0;
		frames_held = 0;
		pop_pos = 0;
	endfunction

	function automatic void drop_head();
		head = (head + 1) % FRAME_SLOTS;
		frames_held--;
		pop_pos = 0;
	endfunction

	// Apply one request to the mirrored buffer and return the response it yields.
	function automatic res_t buffer_step(cmd_t op, logic [BYTE_W-1:0] b);
		res_t        r;
		int unsigned lim;
		int unsigned len;
		int unsigned prev;
		r = '0;
		lim = (max_len > MAX_FRAME) ? MAX_FRAME : max_len;
		case (op)
			CMD_PUSH: begin
				if (lim == 0) begin
					clear_state();
					r.status = STS_BAD_CONFIG;
				end else if (b == CHAR_LF) begin
					if (frames_held >= FRAME_SLOTS) begin
						clear_state();
						r.status = STS_FULL;
					end else begin
						// drop a single carriage return just before the newline
						if (partial_len > 0) begin
							prev = (wr_ptr + STORE_DEPTH - 1) % STORE_DEPTH;
							if (kept_bytes[ADDR_W'(prev)] == CHAR_CR) begin
								wr_ptr = prev;
								used_bytes--;
								partial_len--;
							end
						end
						frame_lengths[SLOT_W'(tail)] = LEN_W'(partial_len);
						tail = (tail + 1) % FRAME_SLOTS;
						frames_held++;
						partial_len = 0;
					end
				end else if (partial_len >= lim) begin
					clear_state();
					r.status = STS_TOO_LONG;
				end else if (used_bytes >= STORE_DEPTH) begin
					clear_state();
					r.status = STS_FULL;
				end else begin
					kept_bytes[ADDR_W'(wr_ptr)] = b;
					wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
					used_bytes++;
					partial_len++;
				end
			end
			CMD_POP: begin
				if (frames_held == 0) begin
					r.status = STS_NO_FRAME;
				end else begin
					len = 32'(frame_lengths[SLOT_W'(head)]);
					if (len == 0) begin
						r.frame_last = 1'b1;
						r.frame_empty = 1'b1;
						drop_head();
					end else begin
						r.out_byte = kept_bytes[ADDR_W'(rd_ptr)];
						r.byte_valid = 1'b1;
						rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
						if (used_bytes > 0)
							used_bytes--;
						pop_pos++;
						if (pop_pos >= len) begin
							r.frame_last = 1'b1;
							drop_head();
						end
					end
				end
			end
			CMD_FLUSH: clear_state();
			default: ;
		endcase
		r.partial_count = LEN_W'(partial_len);
		return r;
	endfunction

	function automatic void compare_field(string field, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			max_len = MAX_FRAME_RESET;
			await_rd = '0;
			await_wr = '0;
			await_cnt = 0;
		end else begin
			// compare before queueing: a response always belongs to an earlier request
			if (out_valid && out_ready) begin
				if (await_cnt == 0) begin
					fail_count++;
					$display("%0t ns: response with none awaited, expected nothing, actual status %0d",
						$time, status);
				end else begin
					want = awaited[await_rd];
					await_rd = await_rd + AWAIT_W'(1);
					await_cnt--;
					compare_field("status", 16'(want.status), 16'(status));
					compare_field("out_byte", 16'(want.out_byte), 16'(out_byte));
					compare_field("byte_valid", 16'(want.byte_valid), 16'(byte_valid));
					compare_field("frame_last", 16'(want.frame_last), 16'(frame_last));
					compare_field("frame_empty", 16'(want.frame_empty), 16'(frame_empty));
					compare_field("partial_count", 16'(want.partial_count),
						16'(partial_count));
					results_checked++;
					if (want.frame_last)
						frames_popped++;
					if (want.status inside {STS_TOO_LONG, STS_BAD_CONFIG, STS_FULL})
						error_responses++;
				end
			end
			if (cfg_wr_en)
				max_len = cfg_wr_data;
			if (in_valid && in_ready) begin
				if (await_cnt == AWAIT_DEPTH) begin
					fail_count++;
					$display("%0t ns: too many responses awaited, expected at most %0d, actual %0d",
						$time, AWAIT_DEPTH - 1, await_cnt);
				end else begin
					awaited[await_wr] = buffer_step(cmd_t'(command), data_byte);
					await_wr = await_wr + AWAIT_W'(1);
					await_cnt++;
				end
			end
		end
		pending_results = await_cnt;
	end

endmodule

>>> test/newline_frame_receive_buffer_tb.sv
`timescale 1ns / 1ps

module newline_frame_receive_buffer_tb;
	import frb_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [LEN_W-1:0]  cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CMD_W-1:0]  command = CMD_NONE;
	logic [BYTE_W-1:0] data_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [STS_W-1:0]  status;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_valid;
	logic              frame_last;
	logic              frame_empty;
	logic [LEN_W-1:0]  partial_count;

	int fail_count, pending_results, results_checked, frames_popped, error_responses;
	int requests_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_cycles = 0;
	bit hold_request = 1'b0;
	bit hold_taken = 1'b0;

	newline_frame_receive_buffer u_dut (.*);

	frame_buffer_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: random stalls, plus one long hold-off so the output backs up.
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (hold_request && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cycles <= 400;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("[newline_frame_receive_buffer] ERROR");
		$finish;
	end

	task automatic send(cmd_t op, logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= op;
		data_byte <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		requests_sent++;
	endtask

	// Hold the input low until every awaited response has come back.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_max_len(logic [LEN_W-1:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_request(int unsigned lf_pct);
		int unsigned       pick;
		int unsigned       roll;
		logic [BYTE_W-1:0] b;
		pick = $urandom_range(99);
		roll = $urandom_range(99);
		b = BYTE_W'($urandom_range(255));
		if (pick < 52) begin
			if (roll < lf_pct)
				b = CHAR_LF;
			else if (roll < lf_pct + 8)
				b = CHAR_CR;
			send(CMD_PUSH, b);
		end else if (pick < 95) begin
			send(CMD_POP, b);
		end else if (pick < 98) begin
			send(CMD_FLUSH, b);
		end else begin
			send(CMD_NONE, b);
		end
	endtask

	task automatic run_phase(int unsigned idle, int unsigned stall, logic [LEN_W-1:0] lim,
			int unsigned lf_pct, int unsigned count);
		set_max_len(lim);
		send_idle_pct = idle;
		stall_pct <= stall;
		repeat (count) random_request(lf_pct);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests at the reset limit
		send(CMD_POP, 8'h00);
		send(CMD_PUSH, CHAR_LF);
		send(CMD_PUSH, 8'hFF);
		send(CMD_PUSH, CHAR_CR);
		send(CMD_PUSH, CHAR_LF);
		send(CMD_PUSH, CHAR_CR);
		send(CMD_PUSH, CHAR_CR);
		send(CMD_PUSH, CHAR_LF);
		send(CMD_PUSH, 8'h00);
		send(CMD_PUSH, 8'h55);
		send(CMD_PUSH, 8'hAA);
		send(CMD_PUSH, CHAR_LF);
		send(CMD_NONE, 8'hFF);
		repeat (7) send(CMD_POP, 8'hFF);
		send(CMD_PUSH, 8'h7F);
		send(CMD_FLUSH, 8'h00);
		send(CMD_POP, 8'h00);

		// smallest limit, carriage return counted as data
		set_max_len(13'd1);
		send(CMD_PUSH, 8'h41);
		send(CMD_PUSH, CHAR_CR);
		send(CMD_PUSH, 8'h41);
		send(CMD_PUSH, CHAR_LF);
		send(CMD_PUSH, CHAR_CR);
		send(CMD_PUSH, CHAR_LF);

		// zero limit: pops still work, any push resets
		set_max_len(13'd0);
		send(CMD_POP, 8'h00);
		send(CMD_PUSH, CHAR_LF);
		send(CMD_POP, 8'h00);
		send(CMD_PUSH, 8'h31);

		hold_request <= 1'b1;
		run_phase(0, 0, 13'd1024, 12, 110);
		run_phase(86, 0, 13'd6, 25, 110);
		// limit above the maximum clamps
		run_phase(0, 86, 13'd8191, 12, 110);
		run_phase(30, 30, 13'd2, 30, 110);

		// overflow the frame length slots with empty frames
		set_max_len(13'd1024);
		repeat (FRAME_SLOTS + 1) send(CMD_PUSH, CHAR_LF);
		send(CMD_POP, 8'h00);

		settle();
		repeat (8) @(posedge clk);
		$display("Checked %0d responses to %0d requests: %0d frames popped, %0d error responses.",
			results_checked, requests_sent, frames_popped, error_responses);
		$display("Limits from 0 to 8191, CR stripping, idle and stall phases, slot overflow.");
		if (fail_count == 0)
			$display("[newline_frame_receive_buffer] OK");
		else
			$display("[newline_frame_receive_buffer] ERROR");
		$finish;
	end

endmodule
